>>> sv/cpa_pkg.sv
// Shared types, constants and the cosine table generator for the cosine
// potential accumulator. No dependencies; every other file imports this package.
package cpa_pkg;

  localparam int PHASE_W     = 24;
  localparam int AMP_W       = 24;
  localparam int VALUE_W     = 32;
  localparam int COS_W       = 17;
  localparam int PROD_W      = AMP_W + COS_W + 1;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int LATENCY     = 5;
  localparam int ROUND_SHIFT = 16;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_X = 3'd0,
    REG_STEP_Y = 3'd1,
    REG_STEP_Z = 3'd2,
    REG_PHASE0 = 3'd3,
    REG_AMP0   = 3'd4,
    REG_PHASE1 = 3'd5,
    REG_AMP1   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]        step_x;
    logic [PHASE_W-1:0]        step_y;
    logic [PHASE_W-1:0]        step_z;
    logic [PHASE_W-1:0]        phase0;
    logic [PHASE_W-1:0]        phase1;
    logic signed [AMP_W-1:0]   amp0;
    logic signed [AMP_W-1:0]   amp1;
  } cfg_regs_t;

  // Control and payload that travel down the pipeline with each item
  typedef struct packed {
    logic                      valid;
    logic                      neg;
    logic signed [AMP_W-1:0]   amp;
    logic signed [VALUE_W-1:0] old;
  } lane_t;

  // Quarter-wave cosine entry, Q16, from a Q30 Taylor series with
  // truncating steps, rounded half up and clamped at zero.
  function automatic logic [COS_W-1:0] cos_entry(input int unsigned idx,
                                                 input int unsigned bits);
    longint unsigned xi;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned q;
    xi   = idx;
    x    = (HALF_PI_Q30 * xi) >> bits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 380; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    q = (longint'(sum) + 64'd8192) >> 14;
    return q[COS_W-1:0];
  endfunction

endpackage

>>> sv/cpa_regs.sv
// Configuration register file: steps, channel phases and amplitudes.
// Depends on cpa_pkg.
module cpa_regs
  import cpa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_regs_t              regs
);

  logic [PHASE_W-1:0] wdata;

  assign cfg_ready = 1'b1;
  assign wdata     = cfg_data[PHASE_W-1:0];

  // Take a write beat; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_X: regs.step_x <= wdata;
        REG_STEP_Y: regs.step_y <= wdata;
        REG_STEP_Z: regs.step_z <= wdata;
        REG_PHASE0: regs.phase0 <= wdata;
        REG_AMP0:   regs.amp0   <= $signed(wdata);
        REG_PHASE1: regs.phase1 <= wdata;
        REG_AMP1:   regs.amp1   <= $signed(wdata);
        default: ;
      endcase
    end
  end

endmodule

>>> sv/cpa_phase.sv
// Phase stages: per-axis step products, then the turn-fraction sum.
// Depends on cpa_pkg.
module cpa_phase
  import cpa_pkg::*;
#(
  parameter int INDEX_BITS   = 10,
  parameter int NUM_CHANNELS = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [INDEX_BITS-1:0]     index_x,
  input  logic [INDEX_BITS-1:0]     index_y,
  input  logic [INDEX_BITS-1:0]     index_z,
  input  logic                      channel,
  input  logic signed [VALUE_W-1:0] old_value,
  input  cfg_regs_t                 regs,
  output lane_t                     lane,
  output logic [PHASE_W-1:0]        phase
);

  logic [PHASE_W-1:0]      ix_ext, iy_ext, iz_ext;
  logic [PHASE_W-1:0]      px_next, py_next, pz_next;
  logic                    present;
  logic signed [AMP_W-1:0] amp_next;
  logic [PHASE_W-1:0]      ph_next;

  lane_t              lane1;
  logic [PHASE_W-1:0] px, py, pz, ph1;

  assign ix_ext = {{(PHASE_W-INDEX_BITS){1'b0}}, index_x};
  assign iy_ext = {{(PHASE_W-INDEX_BITS){1'b0}}, index_y};
  assign iz_ext = {{(PHASE_W-INDEX_BITS){1'b0}}, index_z};

  // Keep only the low bits: the phase wraps at one turn
  assign px_next = regs.step_x * ix_ext;
  assign py_next = regs.step_y * iy_ext;
  assign pz_next = regs.step_z * iz_ext;

  // Absent channel adds nothing: zero amplitude
  assign present  = (NUM_CHANNELS > 1) || (channel == 1'b0);
  assign amp_next = !present ? '0 : (channel ? regs.amp1 : regs.amp0);
  assign ph_next  = channel ? regs.phase1 : regs.phase0;

  // Stage 1: products and channel selection
  always_ff @(posedge clk) begin
    if (rst) begin
      lane1.valid <= 1'b0;
    end else begin
      lane1.valid <= in_valid;
    end
    lane1.neg <= 1'b0;
    lane1.amp <= amp_next;
    lane1.old <= old_value;
    px        <= px_next;
    py        <= py_next;
    pz        <= pz_next;
    ph1       <= ph_next;
  end

  // Stage 2: phase sum modulo one turn
  always_ff @(posedge clk) begin
    if (rst) begin
      lane.valid <= 1'b0;
    end else begin
      lane.valid <= lane1.valid;
    end
    lane.neg <= lane1.neg;
    lane.amp <= lane1.amp;
    lane.old <= lane1.old;
    phase    <= px + py + pz + ph1;
  end

endmodule

>>> sv/cpa_cos_rom.sv
// Quarter-wave cosine lookup stage: quadrant folding and a registered table read.
// Depends on cpa_pkg (table generator).
module cpa_cos_rom
  import cpa_pkg::*;
#(
  parameter int COS_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  lane_t              lane_in,
  input  logic [PHASE_W-1:0] phase,
  output lane_t              lane,
  output logic [COS_W-1:0]   mag
);

  localparam int TABLE_LEN = 1 << COS_TABLE_BITS;
  localparam int ADDR_W    = COS_TABLE_BITS + 1;

  logic [COS_W-1:0]          rom [TABLE_LEN+1];
  logic [1:0]                quad;
  logic [COS_TABLE_BITS-1:0] r;
  logic [ADDR_W-1:0]         addr;

  // Constant table, last entry is cos of a quarter turn
  for (genvar i = 0; i <= TABLE_LEN; i++) begin : g_rom
    localparam logic [COS_W-1:0] ENTRY =
      (i == TABLE_LEN) ? '0 : cos_entry(i, COS_TABLE_BITS);
    assign rom[i] = ENTRY;
  end

  assign quad = phase[PHASE_W-1 -: 2];
  assign r    = phase[PHASE_W-3 -: COS_TABLE_BITS];

  // Mirror the address in the odd quadrants
  assign addr = quad[0] ? ({1'b1, {COS_TABLE_BITS{1'b0}}} - {1'b0, r}) : {1'b0, r};

  // Stage 3: table read and sign of the middle quadrants
  always_ff @(posedge clk) begin
    if (rst) begin
      lane.valid <= 1'b0;
    end else begin
      lane.valid <= lane_in.valid;
    end
    lane.neg <= quad[1] ^ quad[0];
    lane.amp <= lane_in.amp;
    lane.old <= lane_in.old;
    mag      <= rom[addr];
  end

endmodule

>>> sv/cpa_mac.sv
// Multiply-accumulate stages: amplitude times cosine, round, add and saturate.
// Depends on cpa_pkg.
module cpa_mac
  import cpa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  lane_t                     lane_in,
  input  logic [COS_W-1:0]          mag,
  output logic                      done,
  output logic signed [VALUE_W-1:0] new_value
);

  localparam int SCALED_W = PROD_W - ROUND_SHIFT;

  logic signed [COS_W:0]         cosv;
  logic signed [PROD_W-1:0]      prod;
  logic                          valid4;
  logic signed [VALUE_W-1:0]     old4;
  logic signed [PROD_W-1:0]      rnd;
  logic signed [SCALED_W-1:0]    scaled;
  logic signed [VALUE_W:0]       sum;
  logic signed [VALUE_W-1:0]     sat;

  assign cosv = lane_in.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Stage 4: product
  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
    end else begin
      valid4 <= lane_in.valid;
    end
    prod <= lane_in.amp * cosv;
    old4 <= lane_in.old;
  end

  // Round half up to Q16.16 and add with saturation
  assign rnd    = prod + PROD_W'(1 << (ROUND_SHIFT - 1));
  assign scaled = SCALED_W'(rnd >>> ROUND_SHIFT);
  assign sum    = (VALUE_W+1)'(old4) + (VALUE_W+1)'(scaled);

  always_comb begin
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      sat = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      sat = sum[VALUE_W-1:0];
    end
  end

  // Stage 5: result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid4;
    end
    new_value <= sat;
  end

endmodule

>>> sv/cosine_potential_accumulate_top.sv
// Top level of the cosine potential accumulator: config registers and five stages.
// Depends on cpa_pkg, cpa_regs, cpa_phase, cpa_cos_rom, cpa_mac.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  item in  | start, busy (always low)  | index_x, index_y, index_z, channel, old_value
//  result   | done strobe, one cycle    | new_value
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data (low 24 bits kept)
//
// One item enters every cycle; done and new_value are registered together, and
// the result is valid whenever done is high.
// Stages: step products, phase sum, table read, amplitude product, round/add/saturate.
// The table read is the stage that grows with COS_TABLE_BITS.
// Synchronous reset clears the config registers and pipeline valid bits; data is not reset.
// The result side cannot stall, so busy stays low and no beat is held back.
module cosine_potential_accumulate_top
  import cpa_pkg::*;
#(
  parameter int INDEX_BITS     = 10,
  parameter int NUM_CHANNELS   = 2,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [INDEX_BITS-1:0]     index_x,
  input  logic [INDEX_BITS-1:0]     index_y,
  input  logic [INDEX_BITS-1:0]     index_z,
  input  logic                      channel,
  input  logic signed [VALUE_W-1:0] old_value,
  output logic                      done,
  output logic signed [VALUE_W-1:0] new_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_regs_t          regs;
  lane_t              lane2, lane3;
  logic [PHASE_W-1:0] phase;
  logic [COS_W-1:0]   mag;

  assign busy = 1'b0;

  cpa_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  cpa_phase #(
    .INDEX_BITS   (INDEX_BITS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_phase (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .index_x   (index_x),
    .index_y   (index_y),
    .index_z   (index_z),
    .channel   (channel),
    .old_value (old_value),
    .regs      (regs),
    .lane      (lane2),
    .phase     (phase)
  );

  cpa_cos_rom #(
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rst     (rst),
    .lane_in (lane2),
    .phase   (phase),
    .lane    (lane3),
    .mag     (mag)
  );

  cpa_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .lane_in   (lane3),
    .mag       (mag),
    .done      (done),
    .new_value (new_value)
  );

endmodule

>>> sv/cpa_checker.sv
// Port-level checks for the cosine potential accumulator, bound to the top level.
// Depends on cpa_pkg and cosine_potential_accumulate_top.
module cpa_checker
  import cpa_pkg::*;
#(
  parameter int NUM_CHANNELS = 2
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      channel,
  input logic signed [VALUE_W-1:0] old_value,
  input logic                      done,
  input logic signed [VALUE_W-1:0] new_value
);

  // Every accepted beat yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat produced no result");

  // No result without a beat accepted the fixed latency earlier
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted beat");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

  // An absent channel passes the value through unchanged
  a_absent_channel: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (NUM_CHANNELS < 2) && channel) |->
      ##LATENCY (new_value == $past(old_value, LATENCY)))
    else $error("absent channel changed the value");

endmodule

bind cosine_potential_accumulate_top cpa_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_cpa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .channel   (channel),
  .old_value (old_value),
  .done      (done),
  .new_value (new_value)
);

>>> sim/tb_cosine_potential_accumulate_top.sv
// Testbench for cosine_potential_accumulate_top: predicts each new_value from its own
// cosine table and register copy, and checks every done beat in order.
// Depends on cpa_pkg and the RTL of the accumulator.
module tb_cosine_potential_accumulate_top;
  import cpa_pkg::*;

  localparam int INDEX_BITS      = 10;
  localparam int NUM_CHANNELS    = 2;
  localparam int COS_TABLE_BITS  = 10;
  localparam int TABLE_LEN       = 1 << COS_TABLE_BITS;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int SHOWN_ERRORS    = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [INDEX_BITS-1:0]     index_x;
  logic [INDEX_BITS-1:0]     index_y;
  logic [INDEX_BITS-1:0]     index_z;
  logic                      channel;
  logic signed [VALUE_W-1:0] old_value;
  logic                      done;
  logic signed [VALUE_W-1:0] new_value;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // Predictor state: quarter-wave table and a copy of the registers
  int                        cos_quarter [0:TABLE_LEN];
  logic [PHASE_W-1:0]        cur_step_x;
  logic [PHASE_W-1:0]        cur_step_y;
  logic [PHASE_W-1:0]        cur_step_z;
  logic [PHASE_W-1:0]        cur_phase [2];
  logic signed [AMP_W-1:0]   cur_amp [2];

  logic signed [VALUE_W-1:0] expected_values [$];
  int                        error_count = 0;
  int                        cycle_count = 0;
  int                        burst_left  = 0;

  cosine_potential_accumulate_top #(
    .INDEX_BITS     (INDEX_BITS),
    .NUM_CHANNELS   (NUM_CHANNELS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .index_x   (index_x),
    .index_y   (index_y),
    .index_z   (index_z),
    .channel   (channel),
    .old_value (old_value),
    .done      (done),
    .new_value (new_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Quarter-wave cosine in Q16 from a truncating Q30 Taylor series
  function automatic void build_cos_quarter();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int i = 0; i < TABLE_LEN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> COS_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 10; k++) begin
        term = (term * x2) >> 30;
        term = term / (64'(2 * k - 1) * 64'(2 * k));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      cos_quarter[i] = int'((sum + 8192) >>> 14);
    end
    cos_quarter[TABLE_LEN] = 0;
  endfunction

  // Keep the low 24 bits; ignore unknown indexes
  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    logic [PHASE_W-1:0] v;
    v = data[PHASE_W-1:0];
    case (idx)
      REG_STEP_X: cur_step_x   = v;
      REG_STEP_Y: cur_step_y   = v;
      REG_STEP_Z: cur_step_z   = v;
      REG_PHASE0: cur_phase[0] = v;
      REG_AMP0:   cur_amp[0]   = v;
      REG_PHASE1: cur_phase[1] = v;
      REG_AMP1:   cur_amp[1]   = v;
      default: ;
    endcase
  endfunction

  // old + round(amp * cos) with saturation; absent channel passes old through
  function automatic logic signed [VALUE_W-1:0] accumulate_cosine(
    input logic [INDEX_BITS-1:0] x, input logic [INDEX_BITS-1:0] y,
    input logic [INDEX_BITS-1:0] z, input logic ch,
    input logic signed [VALUE_W-1:0] old);
    longint unsigned    phase_sum;
    logic [PHASE_W-1:0] phase;
    int                 r;
    longint             cos_val;
    longint             amp;
    longint             total;
    total = old;
    if (int'(ch) < NUM_CHANNELS) begin
      phase_sum = cur_step_x * x + cur_step_y * y + cur_step_z * z + cur_phase[ch];
      phase     = phase_sum[PHASE_W-1:0];
      r         = phase[21 -: COS_TABLE_BITS];
      case (phase[23:22])
        2'd0:    cos_val = cos_quarter[r];
        2'd1:    cos_val = -cos_quarter[TABLE_LEN - r];
        2'd2:    cos_val = -cos_quarter[r];
        default: cos_val = cos_quarter[TABLE_LEN - r];
      endcase
      amp   = cur_amp[ch];
      total = total + ((amp * cos_val + 32768) >>> 16);
    end
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
    end
    if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
    end
    return total[VALUE_W-1:0];
  endfunction

  function automatic void note_error(input string msg);
    if (error_count < SHOWN_ERRORS) begin
      $display("%s", msg);
    end
    error_count++;
  endfunction

  // Check each done beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_values.size() == 0) begin
        note_error($sformatf("unexpected result: new_value %0d", new_value));
      end else if (new_value !== expected_values[0]) begin
        note_error($sformatf("mismatch: new_value expected %0d got %0d",
                             expected_values[0], new_value));
        void'(expected_values.pop_front());
      end else begin
        void'(expected_values.pop_front());
      end
    end
  end

  // Send one grid point; hold start high until the beat is taken
  task automatic send_point(input logic [INDEX_BITS-1:0] x, input logic [INDEX_BITS-1:0] y,
                            input logic [INDEX_BITS-1:0] z, input logic ch,
                            input logic signed [VALUE_W-1:0] old);
    @(negedge clk);
    start     <= 1'b1;
    index_x   <= x;
    index_y   <= y;
    index_z   <= z;
    channel   <= ch;
    old_value <= old;
    do @(posedge clk); while (busy);
    expected_values.push_back(accumulate_cosine(x, y, z, ch, old));
  endtask

  // Bursts of random length with random gaps, some back to back
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Drop start, wait for every result, then let the pipeline drain
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all registers with junk in the upper bits, plus one unknown index
  task automatic load_regs(input logic [PHASE_W-1:0] sx, input logic [PHASE_W-1:0] sy,
                           input logic [PHASE_W-1:0] sz, input logic [PHASE_W-1:0] p0,
                           input logic [AMP_W-1:0] a0, input logic [PHASE_W-1:0] p1,
                           input logic [AMP_W-1:0] a1);
    settle();
    write_reg(REG_STEP_X, {8'($urandom), sx});
    write_reg(REG_STEP_Y, {8'($urandom), sy});
    write_reg(REG_STEP_Z, {8'($urandom), sz});
    write_reg(REG_PHASE0, {8'($urandom), p0});
    write_reg(REG_AMP0,   {8'($urandom), a0});
    write_reg(REG_PHASE1, {8'($urandom), p1});
    write_reg(REG_AMP1,   {8'($urandom), a1});
    write_reg(REG_UNUSED, $urandom);
  endtask

  // Reset registers are zero: values pass through unchanged
  task automatic test_reset_passthrough();
    send_point('0, '0, '0, 1'b0, 32'sh7FFFFFFF);
    send_point('1, '1, '1, 1'b1, 32'sh80000000);
    send_point('1, '0, '1, 1'b0, 32'sh00000000);
    send_point('0, '1, '0, 1'b1, -32'sd1);
  endtask

  // Quarter-turn x steps hit each quadrant; y walks the table address
  task automatic test_quadrant_boundaries();
    load_regs(24'h400000, 24'h001000, 24'h000000, 24'h000000, 24'h010000,
              24'h200000, 24'h7FFFFF);
    for (int q = 0; q < 4; q++) begin
      send_point(INDEX_BITS'(q), '0, '0, 1'b0, 32'sd0);
      send_point(INDEX_BITS'(q), '1, '0, 1'b1, 32'sd12345);
    end
  endtask

  // Largest amplitudes at cosine one push both rails
  task automatic test_saturation();
    load_regs('0, '0, '0, '0, 24'h7FFFFF, '0, 24'h800000);
    send_point('0, '0, '0, 1'b0, 32'sh7FFFFFFF);
    send_point('0, '0, '0, 1'b1, 32'sh80000000);
    send_point('0, '0, '0, 1'b0, 32'sh7F800000);
    send_point('0, '0, '0, 1'b1, 32'sh80800000);
  endtask

  // Half amplitudes against odd table entries give ties in both signs
  task automatic test_rounding_ties();
    load_regs('0, 24'h001000, '0, 24'h000000, 24'h008000, 24'h000000, 24'hFF8000);
    for (int y = 1; y <= 3; y++) begin
      send_point('0, INDEX_BITS'(y), '0, 1'b0, 32'sd0);
      send_point('0, INDEX_BITS'(y), '0, 1'b1, 32'sd0);
    end
  endtask

  // Maximal steps and offsets force the phase sum to wrap
  task automatic test_phase_wrap();
    load_regs('1, '1, '1, '1, 24'h123456, '1, 24'hEDCBAA);
    send_point('1, '1, '1, 1'b0, 32'sd0);
    send_point('1, '1, '1, 1'b1, 32'sd0);
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return INDEX_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_old_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFFFFFF - $urandom_range(0, 1 << 24);
      1:       return 32'h80000000 + $urandom_range(0, 1 << 24);
      default: return $urandom;
    endcase
  endfunction

  // Random points under several register settings, extremes among them
  task automatic test_random_stream();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1: load_regs('1, '1, '1, '1, 24'h7FFFFF, '1, 24'h800000);
        2: load_regs(24'($urandom_range(0, 4096)), 24'($urandom_range(0, 4096)),
                     24'($urandom_range(0, 4096)), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom));
        3: load_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'h800000, 24'($urandom), 24'h000000);
        default: load_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                           24'($urandom), 24'($urandom), 24'($urandom));
      endcase
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pace_sender();
        send_point(pick_index(), pick_index(), pick_index(), 1'($urandom),
                   pick_old_value());
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    index_x   = '0;
    index_y   = '0;
    index_z   = '0;
    channel   = 1'b0;
    old_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    build_cos_quarter();
    apply_reg_write(REG_STEP_X, '0);
    apply_reg_write(REG_STEP_Y, '0);
    apply_reg_write(REG_STEP_Z, '0);
    apply_reg_write(REG_PHASE0, '0);
    apply_reg_write(REG_AMP0, '0);
    apply_reg_write(REG_PHASE1, '0);
    apply_reg_write(REG_AMP1, '0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_passthrough();
    test_quadrant_boundaries();
    test_saturation();
    test_rounding_ties();
    test_phase_wrap();
    test_random_stream();

    settle();
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
